@@ sv/ovt_pkg.sv @@
// Shared constants and types for the oriented rectangle overlap test.
package ovt_pkg;

  localparam int COORD_BITS = 16;
  localparam int AXIS_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS + 1;
  localparam int PROJ_BITS  = 2 * COORD_BITS + 2;
  localparam int ADDR_BITS  = 3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_3 = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 cap_t;
    logic                 do_sub;
    logic                 mul_x;
    logic                 mul_y;
    logic                 cmp;
    logic                 first;
    logic                 rect;
  } ctrl_t;

endpackage

@@ sv/ovt_store.sv @@
// Corner store: eight x/y entries, one write and one registered read port.
module ovt_store (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ovt_pkg::ADDR_BITS-1:0]       waddr,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] wx,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] wy,
  input  logic [ovt_pkg::ADDR_BITS-1:0]       raddr,
  output logic signed [ovt_pkg::COORD_BITS-1:0] rd_x,
  output logic signed [ovt_pkg::COORD_BITS-1:0] rd_y
);

  localparam int DEPTH = 1 << ovt_pkg::ADDR_BITS;

  logic signed [ovt_pkg::COORD_BITS-1:0] mem_x [DEPTH];
  logic signed [ovt_pkg::COORD_BITS-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
  end

endmodule

@@ sv/ovt_datapath.sv @@
// Axis builder, shared multiply-add unit and per-rectangle min/max tracking.
module ovt_datapath (
  input  logic                                  clk,
  input  ovt_pkg::ctrl_t                        ctrl,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] rd_x,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] rd_y,
  output logic                                  sep
);

  logic signed [ovt_pkg::COORD_BITS-1:0] t_x;
  logic signed [ovt_pkg::COORD_BITS-1:0] t_y;
  logic signed [ovt_pkg::AXIS_BITS-1:0]  ax;
  logic signed [ovt_pkg::AXIS_BITS-1:0]  ay;
  logic signed [ovt_pkg::COORD_BITS-1:0] mul_a;
  logic signed [ovt_pkg::AXIS_BITS-1:0]  mul_b;
  logic signed [ovt_pkg::PROD_BITS-1:0]  mul_p;
  logic signed [ovt_pkg::PROD_BITS-1:0]  prod;
  logic signed [ovt_pkg::PROJ_BITS-1:0]  proj;
  logic signed [ovt_pkg::PROJ_BITS-1:0]  amin;
  logic signed [ovt_pkg::PROJ_BITS-1:0]  amax;
  logic signed [ovt_pkg::PROJ_BITS-1:0]  bmin;
  logic signed [ovt_pkg::PROJ_BITS-1:0]  bmax;

  assign mul_a = ctrl.mul_y ? rd_y : rd_x;
  assign mul_b = ctrl.mul_y ? ay : ax;
  assign mul_p = (ovt_pkg::PROD_BITS)'(mul_a) * (ovt_pkg::PROD_BITS)'(mul_b);

  always_ff @(posedge clk) begin
    if (ctrl.cap_t) begin
      t_x <= rd_x;
      t_y <= rd_y;
    end
    if (ctrl.do_sub) begin
      ax <= {t_x[ovt_pkg::COORD_BITS-1], t_x} - {rd_x[ovt_pkg::COORD_BITS-1], rd_x};
      ay <= {t_y[ovt_pkg::COORD_BITS-1], t_y} - {rd_y[ovt_pkg::COORD_BITS-1], rd_y};
    end
    if (ctrl.mul_x) begin
      prod <= mul_p;
    end
    if (ctrl.mul_y) begin
      proj <= {prod[ovt_pkg::PROD_BITS-1], prod} + {mul_p[ovt_pkg::PROD_BITS-1], mul_p};
    end
    if (ctrl.cmp) begin
      if (!ctrl.rect) begin
        if (ctrl.first || proj < amin) amin <= proj;
        if (ctrl.first || proj > amax) amax <= proj;
      end else begin
        if (ctrl.first || proj < bmin) bmin <= proj;
        if (ctrl.first || proj > bmax) bmax <= proj;
      end
    end
  end

  assign sep = (amin > bmax) || (amax < bmin);

endmodule

@@ sv/ovt_ctrl.sv @@
// Sequencer over axes and corners, input handshake and result register.
module ovt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           kind,
  input  logic           out_stall,
  input  logic           sep,
  output logic           in_stall,
  output logic           out_valid,
  output logic           collides,
  output ovt_pkg::ctrl_t ctrl
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_AX_RD1 = 10'b0000000010,
    S_AX_RD2 = 10'b0000000100,
    S_AX_SUB = 10'b0000001000,
    S_LD     = 10'b0000010000,
    S_MUL_X  = 10'b0000100000,
    S_MUL_Y  = 10'b0001000000,
    S_CMP    = 10'b0010000000,
    S_CHECK  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] axis;
  logic [2:0] corner;
  logic       res;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid && kind == ovt_pkg::KIND_TEST) state_next = S_AX_RD1;
      S_AX_RD1: state_next = S_AX_RD2;
      S_AX_RD2: state_next = S_AX_SUB;
      S_AX_SUB: state_next = S_LD;
      S_LD:     state_next = S_MUL_X;
      S_MUL_X:  state_next = S_MUL_Y;
      S_MUL_Y:  state_next = S_CMP;
      S_CMP:    state_next = (corner == 3'd7) ? S_CHECK : S_LD;
      S_CHECK:  state_next = (sep || axis == 2'd3) ? S_FINISH : S_AX_RD1;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      axis      <= 2'd0;
      corner    <= 3'd0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE:   axis <= 2'd0;
        S_AX_SUB: corner <= 3'd0;
        S_CMP:    if (corner != 3'd7) corner <= corner + 3'd1;
        S_CHECK: begin
          res <= !sep;
          if (!sep && axis != 2'd3) axis <= axis + 2'd1;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            collides  <= res;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl         = '0;
    ctrl.rd_addr = corner;
    ctrl.first   = (corner[1:0] == ovt_pkg::CORNER_0);
    ctrl.rect    = corner[2];
    case (state)
      S_AX_RD1: ctrl.rd_addr = {axis[1], ovt_pkg::CORNER_1};
      S_AX_RD2: begin
        ctrl.rd_addr = {axis[1], axis[0] ? ovt_pkg::CORNER_3 : ovt_pkg::CORNER_0};
        ctrl.cap_t   = 1'b1;
      end
      S_AX_SUB: ctrl.do_sub = 1'b1;
      S_MUL_X:  ctrl.mul_x  = 1'b1;
      S_MUL_Y:  ctrl.mul_y  = 1'b1;
      S_CMP:    ctrl.cmp    = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/oriented_rectangle_overlap_test_top.sv @@
// Top level of the oriented rectangle overlap test.
// A load transaction (kind 0) writes one corner of rectangle A or B into the corner
// store. A test transaction (kind 1) runs the separating-axis test on the stored
// corners and yields one collides result; the block stalls its input for the whole
// test. The test runs on one shared multiply-add unit under the sequencer: each of
// the four axes is built by reading two corners from the store and subtracting them,
// then each of the eight corners is projected in load, x-multiply, y-multiply and
// compare steps, and the axis is checked; the test ends early when an axis
// separates. Every corner must be loaded before the first test.
module oriented_rectangle_overlap_test_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic                                  rect_sel,
  input  logic [1:0]                            corner_index,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] x_coord,
  input  logic signed [ovt_pkg::COORD_BITS-1:0] y_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  collides
);

  ovt_pkg::ctrl_t                        ctrl;
  logic                                  sep;
  logic                                  we;
  logic signed [ovt_pkg::COORD_BITS-1:0] rd_x;
  logic signed [ovt_pkg::COORD_BITS-1:0] rd_y;

  assign we = in_valid && !in_stall && (kind == ovt_pkg::KIND_LOAD);

  ovt_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr ({rect_sel, corner_index}),
    .wx    (x_coord),
    .wy    (y_coord),
    .raddr (ctrl.rd_addr),
    .rd_x  (rd_x),
    .rd_y  (rd_y)
  );

  ovt_datapath u_datapath (
    .clk  (clk),
    .ctrl (ctrl),
    .rd_x (rd_x),
    .rd_y (rd_y),
    .sep  (sep)
  );

  ovt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .out_stall (out_stall),
    .sep       (sep),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .collides  (collides),
    .ctrl      (ctrl)
  );

endmodule

@@ tb/sv/oriented_rectangle_overlap_test_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the oriented rectangle overlap block: directed table, then random.
module oriented_rectangle_overlap_test_top_test;

  localparam logic RECT_A = 1'b0;
  localparam logic RECT_B = 1'b1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic signed [ovt_pkg::COORD_BITS-1:0] COORD_MIN =
    {1'b1, {(ovt_pkg::COORD_BITS-1){1'b0}}};
  localparam logic signed [ovt_pkg::COORD_BITS-1:0] COORD_MAX =
    {1'b0, {(ovt_pkg::COORD_BITS-1){1'b1}}};
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int PRINT_LIMIT   = 100;
  localparam int DIRECTED_ROWS = 23;

  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_CLEAR, CHECK_HIT} check_t;

  typedef struct packed {
    logic                                  kind;
    logic                                  rect;
    logic [1:0]                            corner;
    logic signed [ovt_pkg::COORD_BITS-1:0] x;
    logic signed [ovt_pkg::COORD_BITS-1:0] y;
  } corner_txn_t;

  typedef struct packed {
    corner_txn_t txn;
    check_t      check;
  } directed_row_t;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_0, 16'sd0,   16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_1, 16'sd10,  16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, CORNER_2,          16'sd10,  16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_3, 16'sd0,   16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_0, 16'sd0,   16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_1, 16'sd10,  16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, CORNER_2,          16'sd10,  16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_3, 16'sd0,   16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_TEST, RECT_A, ovt_pkg::CORNER_0, 16'sd0,   16'sd0},  CHECK_HIT},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_0, 16'sd100, 16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_1, 16'sd110, 16'sd0},  CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, CORNER_2,          16'sd110, 16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_3, 16'sd100, 16'sd10}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_TEST, RECT_A, ovt_pkg::CORNER_0, 16'sd0,   16'sd0},  CHECK_CLEAR},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_0, COORD_MIN, COORD_MIN}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_1, COORD_MAX, COORD_MIN}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, CORNER_2,          COORD_MAX, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_A, ovt_pkg::CORNER_3, COORD_MIN, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_0, COORD_MAX, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_1, COORD_MAX, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, CORNER_2,          COORD_MAX, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_LOAD, RECT_B, ovt_pkg::CORNER_3, COORD_MAX, COORD_MAX}, CHECK_PREDICTED},
    '{'{ovt_pkg::KIND_TEST, RECT_B, ovt_pkg::CORNER_3, COORD_MAX, COORD_MIN}, CHECK_HIT}
  };

  logic                                  clk          = 1'b0;
  logic                                  rst          = 1'b1;
  logic                                  in_valid     = 1'b0;
  logic                                  kind         = ovt_pkg::KIND_LOAD;
  logic                                  rect_sel     = RECT_A;
  logic [1:0]                            corner_index = ovt_pkg::CORNER_0;
  logic signed [ovt_pkg::COORD_BITS-1:0] x_coord      = '0;
  logic signed [ovt_pkg::COORD_BITS-1:0] y_coord      = '0;
  logic                                  out_stall    = 1'b0;
  logic                                  in_stall;
  logic                                  out_valid;
  logic                                  collides;

  logic signed [ovt_pkg::COORD_BITS-1:0] corner_x [8];
  logic signed [ovt_pkg::COORD_BITS-1:0] corner_y [8];
  logic                                  pending_collides [$];
  logic                                  collides_want;

  int error_count       = 0;
  int loads_sent        = 0;
  int tests_sent        = 0;
  int results_seen      = 0;
  int hits_seen         = 0;
  int idle_cycles       = 0;
  int sender_idle_pct   = 18;
  int receiver_idle_pct = 46;

  oriented_rectangle_overlap_test_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .rect_sel     (rect_sel),
    .corner_index (corner_index),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .collides     (collides)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  function automatic logic predict_collision();
    logic signed [ovt_pkg::AXIS_BITS-1:0] axis_x [4];
    logic signed [ovt_pkg::AXIS_BITS-1:0] axis_y [4];
    logic signed [ovt_pkg::PROJ_BITS-1:0] proj;
    logic signed [ovt_pkg::PROJ_BITS-1:0] lo [2];
    logic signed [ovt_pkg::PROJ_BITS-1:0] hi [2];
    int base;
    for (int r = 0; r < 2; r++) begin
      base = 4 * r;
      axis_x[2*r]   = (ovt_pkg::AXIS_BITS)'(corner_x[base+1]) -
                      (ovt_pkg::AXIS_BITS)'(corner_x[base]);
      axis_y[2*r]   = (ovt_pkg::AXIS_BITS)'(corner_y[base+1]) -
                      (ovt_pkg::AXIS_BITS)'(corner_y[base]);
      axis_x[2*r+1] = (ovt_pkg::AXIS_BITS)'(corner_x[base+1]) -
                      (ovt_pkg::AXIS_BITS)'(corner_x[base+3]);
      axis_y[2*r+1] = (ovt_pkg::AXIS_BITS)'(corner_y[base+1]) -
                      (ovt_pkg::AXIS_BITS)'(corner_y[base+3]);
    end
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 2; r++) begin
        for (int i = 0; i < 4; i++) begin
          proj = (ovt_pkg::PROJ_BITS)'(corner_x[4*r+i]) * (ovt_pkg::PROJ_BITS)'(axis_x[k]) +
                 (ovt_pkg::PROJ_BITS)'(corner_y[4*r+i]) * (ovt_pkg::PROJ_BITS)'(axis_y[k]);
          if (i == 0 || proj < lo[r]) lo[r] = proj;
          if (i == 0 || proj > hi[r]) hi[r] = proj;
        end
      end
      if (lo[0] > hi[1] || hi[0] < lo[1]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void record_accepted(input corner_txn_t t, input check_t check);
    logic want;
    if (t.kind == ovt_pkg::KIND_LOAD) begin
      corner_x[{t.rect, t.corner}] = t.x;
      corner_y[{t.rect, t.corner}] = t.y;
      loads_sent++;
    end else begin
      tests_sent++;
      case (check)
        CHECK_HIT:   want = 1'b1;
        CHECK_CLEAR: want = 1'b0;
        default:     want = predict_collision();
      endcase
      pending_collides = {pending_collides, want};
    end
  endfunction

  function automatic corner_txn_t load_txn(input logic rect, input logic [1:0] corner,
                                           input int x, input int y);
    return '{ovt_pkg::KIND_LOAD, rect, corner, ovt_pkg::COORD_BITS'(x),
             ovt_pkg::COORD_BITS'(y)};
  endfunction

  function automatic corner_txn_t test_txn();
    return '{ovt_pkg::KIND_TEST, 1'($urandom), 2'($urandom), ovt_pkg::COORD_BITS'($urandom),
             ovt_pkg::COORD_BITS'($urandom)};
  endfunction

  task automatic send_txn(input corner_txn_t t, input check_t check);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    kind         <= t.kind;
    rect_sel     <= t.rect;
    corner_index <= t.corner;
    x_coord      <= t.x;
    y_coord      <= t.y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_accepted(t, check);
  endtask

  task automatic send_rect_pair(input bit wild);
    int px [8];
    int py [8];
    int order [8];
    int cx, cy, ux, uy, m, j, tmp;
    cx = 0;
    cy = 0;
    for (int r = 0; r < 2; r++) begin
      if (r == 0) begin
        cx = $urandom_range(24000) - 12000;
        cy = $urandom_range(24000) - 12000;
      end else begin
        cx = cx + $urandom_range(16000) - 8000;
        cy = cy + $urandom_range(16000) - 8000;
      end
      ux = $urandom_range(4000) - 2000;
      uy = $urandom_range(4000) - 2000;
      m  = $urandom_range(4);
      px[4*r]   = cx - ux + uy * m;
      py[4*r]   = cy - uy - ux * m;
      px[4*r+1] = cx + ux + uy * m;
      py[4*r+1] = cy + uy - ux * m;
      px[4*r+2] = cx + ux - uy * m;
      py[4*r+2] = cy + uy + ux * m;
      px[4*r+3] = cx - ux - uy * m;
      py[4*r+3] = cy - uy + ux * m;
    end
    for (int i = 0; i < 8; i++) begin
      if (wild) begin
        px[i] = $urandom_range(65535) - 32768;
        py[i] = $urandom_range(65535) - 32768;
      end
      order[i] = i;
    end
    for (int i = 7; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 8; i++) begin
      send_txn(load_txn(order[i][2], order[i][1:0], px[order[i]], py[order[i]]),
               CHECK_PREDICTED);
    end
    send_txn(test_txn(), CHECK_PREDICTED);
  endtask

  task automatic run_random(input int n);
    int target, pick;
    target = loads_sent + tests_sent + n;
    while (loads_sent + tests_sent < target) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_rect_pair($urandom_range(3) == 0);
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 3)) begin
          send_txn(load_txn(1'($urandom), 2'($urandom), $urandom_range(24000) - 12000,
                            $urandom_range(24000) - 12000), CHECK_PREDICTED);
        end
        send_txn(test_txn(), CHECK_PREDICTED);
      end else begin
        send_txn('{1'($urandom), 1'($urandom), 2'($urandom), ovt_pkg::COORD_BITS'($urandom),
                   ovt_pkg::COORD_BITS'($urandom)}, CHECK_PREDICTED);
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_collides.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, collides=%0b", collides));
      end else begin
        collides_want = pending_collides.pop_front();
        if (collides !== collides_want) begin
          report_mismatch($sformatf("result %0d: collides=%0b, want %0b",
                                    results_seen, collides, collides_want));
        end
        if (collides_want) hits_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_txn(DIRECTED[i].txn, DIRECTED[i].check);
    end
    run_random(RANDOM_ITEMS / 3);
    sender_idle_pct   = 46;
    receiver_idle_pct = 18;
    run_random(RANDOM_ITEMS / 3);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_collides.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d corner loads and %0d overlap tests; %0d results checked, %0d hits.",
             loads_sent, tests_sent, results_seen, hits_seen);
    $display("Idle mixes: sender 18/receiver 46, sender 46/receiver 18, none; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
